### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational implication checked at every clock edge outside reset
`define N2A_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the clock cycle after the antecedent
`define N2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/n2a_pkg.sv
`default_nettype none

package n2a_pkg;

    typedef enum logic [1:0] {
        REQ_CHAR = 2'd0,
        REQ_DEC  = 2'd1,
        REQ_BIN  = 2'd2,
        REQ_HEX  = 2'd3
    } req_type_t;

    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_B     = 8'h62;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [3:0] NIBBLE_MAX  = 4'd9;

    // character position within a run
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_FIRST      = 5'd0;
    localparam logic [POS_W-1:0] POS_SECOND     = 5'd1;
    localparam logic [POS_W-1:0] DEC_LAST_POS   = 5'd4;
    localparam logic [POS_W-1:0] BIN_SPACE_POS  = 5'd10;
    localparam logic [POS_W-1:0] BIN_HIGH_END   = 5'd9;
    localparam logic [POS_W-1:0] BIN_LONG_LAST  = 5'd18;
    localparam logic [POS_W-1:0] BIN_SHORT_LAST = 5'd9;
    localparam logic [POS_W-1:0] HEX_LONG_LAST  = 5'd5;
    localparam logic [POS_W-1:0] HEX_SHORT_LAST = 5'd3;

    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n);
        logic [7:0] c;
        if (n > NIBBLE_MAX) begin
            c = ASCII_A + {4'd0, n - 4'd10};
        end else begin
            c = ASCII_ZERO + {4'd0, n};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/number_to_ascii_formatter.sv
`default_nettype none

// Formats one request word (mode on s_tuser, 16-bit value on s_tdata) into a run
// of ASCII characters, one character per output word, with m_tlast on the final
// character. Char mode sends the low byte and puts a carriage return before a
// newline; decimal mode sends up to five digits without leading zeros (a lone 0
// for zero); binary mode sends "0b" and 8 bits, or 16 bits with a space after
// the high byte when the value exceeds 0xFF; hex mode sends "0x" and 2 or 4
// upper-case digits on the same width rule. A single character sequencer walks
// the run one position per cycle while the output register can take the word or
// the position sends nothing, and stalls otherwise. A run has char 1 or 2
// positions, decimal always 5 (a skipped leading zero still takes its position),
// binary 10 or 19, hex 4 or 6. The next request word is taken in the same cycle
// the last character of the current run is generated, and the output register
// lets a request word be taken while a finished character still waits on m_tready.
module number_to_ascii_formatter
    import n2a_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] char_out
    output logic             m_tlast    // last_char
);

    // request being formatted
    logic             item_valid_reg;
    req_type_t        type_reg;
    logic [15:0]      value_reg;
    logic [POS_W-1:0] pos_reg;
    logic [15:0]      rem_reg;      // decimal remainder still to print
    logic             started_reg;  // a nonzero decimal digit has gone out

    // output word register
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;

    // character generator
    logic        gen_emit;
    logic        gen_last;
    logic [7:0]  gen_char;
    logic [15:0] dec_sub;
    logic [3:0]  dec_digit;
    logic [16:0] dec_pow;
    logic [4:0]  bit_pos;
    logic [1:0]  nib_pos;
    logic        long_form;

    logic out_ready;
    logic adv;
    logic done;
    logic in_accept;

    assign long_form = value_reg[15:8] != 8'd0;

    always_comb begin
        gen_char  = ASCII_ZERO;
        gen_emit  = 1'b1;
        gen_last  = 1'b0;
        dec_digit = 4'd0;
        dec_sub   = 16'd0;
        dec_pow   = 17'd1;
        bit_pos   = 5'd0;
        nib_pos   = 2'd0;
        case (type_reg)
            REQ_CHAR: begin
                // newline goes out as carriage return then newline
                if (value_reg[7:0] == ASCII_LF && pos_reg == POS_FIRST) begin
                    gen_char = ASCII_CR;
                end else begin
                    gen_char = value_reg[7:0];
                    gen_last = 1'b1;
                end
            end
            REQ_DEC: begin
                case (pos_reg[2:0])
                    3'd0:    dec_pow = 17'd10000;
                    3'd1:    dec_pow = 17'd1000;
                    3'd2:    dec_pow = 17'd100;
                    3'd3:    dec_pow = 17'd10;
                    default: dec_pow = 17'd1;
                endcase
                // remainder is below ten times the weight, so nine compares pick the digit
                for (int k = 1; k <= 9; k++) begin
                    if ({1'b0, rem_reg} >= dec_pow * 17'(k)) begin
                        dec_digit = 4'(k);
                        dec_sub   = 16'(dec_pow * 17'(k));
                    end
                end
                gen_char = ASCII_ZERO + {4'd0, dec_digit};
                gen_emit = (dec_digit != 4'd0) || started_reg || (pos_reg == DEC_LAST_POS);
                gen_last = pos_reg == DEC_LAST_POS;
            end
            REQ_BIN: begin
                if (long_form) begin
                    bit_pos = (pos_reg <= BIN_HIGH_END) ? 5'd17 - pos_reg : 5'd18 - pos_reg;
                end else begin
                    bit_pos = 5'd9 - pos_reg;
                end
                if (pos_reg == POS_FIRST) begin
                    gen_char = ASCII_ZERO;
                end else if (pos_reg == POS_SECOND) begin
                    gen_char = ASCII_B;
                end else if (long_form && pos_reg == BIN_SPACE_POS) begin
                    gen_char = ASCII_SPACE;
                end else begin
                    gen_char = value_reg[bit_pos[3:0]] ? ASCII_ONE : ASCII_ZERO;
                end
                gen_last = pos_reg == (long_form ? BIN_LONG_LAST : BIN_SHORT_LAST);
            end
            REQ_HEX: begin
                nib_pos = 2'((long_form ? HEX_LONG_LAST : HEX_SHORT_LAST) - pos_reg);
                if (pos_reg == POS_FIRST) begin
                    gen_char = ASCII_ZERO;
                end else if (pos_reg == POS_SECOND) begin
                    gen_char = ASCII_X;
                end else begin
                    gen_char = nibble_to_ascii(value_reg[{nib_pos, 2'b00} +: 4]);
                end
                gen_last = pos_reg == (long_form ? HEX_LONG_LAST : HEX_SHORT_LAST);
            end
            default: begin
                gen_last = 1'b1;
            end
        endcase
    end

    // a position advances when its word fits in the output register or sends nothing
    assign out_ready = !m_valid_reg || m_tready;
    assign adv       = item_valid_reg && (out_ready || !gen_emit);
    assign done      = adv && gen_last;
    assign s_tready  = !item_valid_reg || done;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (in_accept) begin
                item_valid_reg <= 1'b1;
            end else if (done) begin
                item_valid_reg <= 1'b0;
            end
            if (adv && gen_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            type_reg    <= req_type_t'(s_tuser);
            value_reg   <= s_tdata;
            rem_reg     <= s_tdata;
            pos_reg     <= POS_FIRST;
            started_reg <= 1'b0;
        end else if (adv) begin
            pos_reg     <= pos_reg + 5'd1;
            rem_reg     <= rem_reg - dec_sub;
            started_reg <= started_reg | gen_emit;
        end
        if (adv && gen_emit) begin
            m_data_reg <= gen_char;
            m_last_reg <= gen_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

### rtl/core/n2a_checker.sv
`default_nettype none

`include "assert_macros.svh"

module n2a_checker
    import n2a_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    logic out_taken;
    logic out_stall;

    assign out_taken = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;

    // stalled word keeps its payload
    `N2A_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")

    // a stalled word that is not last means a run is still open, so no new request
    `N2A_ASSERT_SAME(a_busy_no_take, aclk, aresetn, out_stall && !m_tlast, !s_tready, "request taken while a run is open")

    // carriage return in mid run only comes from a newline, which follows at once
    `N2A_ASSERT_NEXT(a_cr_then_lf, aclk, aresetn, out_taken && !m_tlast && m_tdata == ASCII_CR, m_tvalid && m_tlast && m_tdata == ASCII_LF, "carriage return not followed by newline")

    // binary prefix is followed at once by a bit digit
    `N2A_ASSERT_NEXT(a_bin_digit, aclk, aresetn, out_taken && !m_tlast && m_tdata == ASCII_B, m_tvalid && (m_tdata == ASCII_ZERO || m_tdata == ASCII_ONE), "binary prefix not followed by a bit")

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (.*);

`default_nettype wire
